FILE: src/image_packet_reassembly_macros.svh
// Assertion macros for the image packet reassembly block.
`ifndef IMAGE_PACKET_REASSEMBLY_MACROS_SVH
`define IMAGE_PACKET_REASSEMBLY_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define IPR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("image_packet_reassembly: assertion failed");
// Next-cycle implication, checked out of reset.
`define IPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("image_packet_reassembly: assertion failed");
`else
`define IPR_ASSERT_SAME(label, ante, cons)
`define IPR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/ipr_pkg.sv
// Package of types and constants for the image packet reassembly block.
`default_nettype none
package ipr_pkg;

  // Sizing
  localparam int MAX_PACKETS   = 64;
  localparam int PAYLOAD_BYTES = 1024;
  localparam int IMAGE_DEPTH   = 65536;
  localparam int MAP_IW        = $clog2(MAX_PACKETS);
  localparam int PAY_LW        = $clog2(PAYLOAD_BYTES);
  localparam int IMG_AW        = $clog2(IMAGE_DEPTH);
  localparam int WADDR_W       = 17;

  // Field types
  typedef logic [1:0]  req_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] num_t;
  typedef logic [15:0] raddr_t;
  typedef logic [2:0]  kind_t;
  typedef logic [10:0] pos_t;
  typedef logic [16:0] cfg_data_t;
  typedef logic [0:0]  cfg_idx_t;
  typedef logic [MAX_PACKETS-1:0] map_t;

  // Request codes
  localparam req_t REQ_PACKET = 2'd0;
  localparam req_t REQ_LIST   = 2'd1;
  localparam req_t REQ_READ   = 2'd2;
  localparam req_t REQ_NEW    = 2'd3;

  // Result kinds
  localparam kind_t KIND_PENDING  = 3'd0;
  localparam kind_t KIND_COMPLETE = 3'd1;
  localparam kind_t KIND_SOME     = 3'd2;
  localparam kind_t KIND_MISSING  = 3'd3;
  localparam kind_t KIND_IMAGE    = 3'd4;
  localparam kind_t KIND_DROPPED  = 3'd5;

  // Register indexes
  localparam cfg_idx_t CFG_PACKET_COUNT = 1'd0;
  localparam cfg_idx_t CFG_IMAGE_BYTES  = 1'd1;

  // Packet layout
  localparam pos_t POS_NUM_HI    = 11'd6;
  localparam pos_t POS_NUM_LO    = 11'd7;
  localparam pos_t POS_STORE     = 11'd13;
  localparam pos_t POS_MAX       = 11'd2047;

endpackage
`default_nettype wire

FILE: src/image_packet_reassembly.sv
// Image packet reassembly: packet byte intake, received bitmap, image memory, missing list.
//
// Packet bytes, image reads and new-picture requests are taken one per cycle with busy low;
// the one result of a packet end or a read shows in the cycle after the item is taken (a read
// comes straight from the image memory's registered read port). A missing-list request with
// nothing missing gives its single result the next cycle and leaves busy low; otherwise busy
// rises and the bitmap is walked one entry per cycle from packet 1 up to the highest missing
// number, so the request holds the block for the walk, emitting one result per missing
// packet. Results appear on out_valid for exactly one cycle and cannot be held off.
// Configuration writes take effect at once and are to be made only while the block is idle.
`default_nettype none
module image_packet_reassembly (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ipr_pkg::req_t      in_req_type,
  input  wire ipr_pkg::byte_t     in_data_byte,
  input  wire logic               in_packet_end,
  input  wire ipr_pkg::raddr_t    in_read_address,
  input  wire logic               cfg_we,
  input  wire ipr_pkg::cfg_idx_t  cfg_index,
  input  wire ipr_pkg::cfg_data_t cfg_data,
  output logic                    out_valid,
  output ipr_pkg::kind_t          out_kind,
  output ipr_pkg::num_t           out_packet_number,
  output ipr_pkg::byte_t          out_image_data,
  output logic                    out_last
);
  import ipr_pkg::*;

  // Configuration
  logic [6:0]  packet_count_r;
  logic [16:0] image_bytes_r;

  // Picture and packet state
  map_t  map_r, map_nxt;
  logic  fpd_r, fpd_nxt;
  logic  all_r, all_nxt;
  pos_t  pos_r, pos_nxt;
  num_t  num_r, num_nxt;
  byte_t td0_r, td0_nxt, td1_r, td1_nxt;

  // Missing-list walk
  logic              walk_r, walk_nxt;
  logic [MAP_IW-1:0] idx_r, idx_nxt;

  // Result register
  logic  out_valid_r, out_valid_nxt;
  kind_t out_kind_r, out_kind_nxt;
  num_t  out_num_r, out_num_nxt;
  logic  out_last_r, out_last_nxt;

  // Image memory
  byte_t img_mem [IMAGE_DEPTH];
  byte_t rd_q_r;

  // Datapath intermediates
  logic                accept;
  logic [6:0]          eff_count;
  num_t                cnt16;
  map_t                mask;
  map_t                miss;
  map_t                rest;
  map_t                map_set;
  num_t                num_new;
  num_t                slot;
  num_t                end_num;
  num_t                end_slot;
  pos_t                off;
  logic [WADDR_W-1:0]  wr_addr;
  logic                store_ok;
  logic                wr_en;
  logic                rd_en;
  logic                drop;
  logic                full;
  logic                fpd_new;
  logic                all_new;

  assign accept = start && !busy;
  assign busy   = walk_r;

  // Effective packet count and its bitmap mask
  assign eff_count = (packet_count_r > 7'(MAX_PACKETS)) ? 7'(MAX_PACKETS) : packet_count_r;
  assign cnt16     = 16'(eff_count);
  always_comb begin
    for (int i = 0; i < MAX_PACKETS; i++) begin
      mask[i] = (7'(i) < eff_count);
    end
  end
  assign miss = ~map_r & mask;
  assign rest = miss & ~((map_t'(2) << idx_r) - map_t'(1));

  // Assemble the packet number from bytes six and seven
  always_comb begin
    num_new = num_r;
    if (pos_r == POS_NUM_HI) begin
      num_new = {in_data_byte, num_r[7:0]};
    end else if (pos_r == POS_NUM_LO) begin
      num_new = {num_r[15:8], in_data_byte};
    end
  end

  // Payload store address and gating
  assign slot     = num_new - 16'd1;
  assign off      = pos_r - POS_STORE;
  assign store_ok = (pos_r >= POS_STORE) && (pos_r < POS_MAX) &&
                    (num_new != 16'd0) && (num_new <= cnt16);
  assign wr_addr  = (WADDR_W'(slot[MAP_IW-1:0]) << PAY_LW) + WADDR_W'(off);
  assign wr_en    = accept && (in_req_type == REQ_PACKET) && store_ok &&
                    (wr_addr < image_bytes_r) && (wr_addr < WADDR_W'(IMAGE_DEPTH));
  assign rd_en    = accept && (in_req_type == REQ_READ);

  // Packet end: bitmap update and completeness
  assign end_num  = (pos_r >= POS_NUM_LO) ? num_new : 16'd0;
  assign end_slot = end_num - 16'd1;
  assign drop     = (end_num == 16'd0) || (end_num > cnt16);
  assign map_set  = drop ? map_t'(0) : (map_t'(1) << end_slot[MAP_IW-1:0]);
  assign fpd_new  = fpd_r || (!drop && (end_num == cnt16));
  assign full     = &((map_r | map_set) | ~mask);
  assign all_new  = all_r || (fpd_new && full);

  // Next-state logic
  always_comb begin
    map_nxt       = map_r;
    fpd_nxt       = fpd_r;
    all_nxt       = all_r;
    pos_nxt       = pos_r;
    num_nxt       = num_r;
    td0_nxt       = td0_r;
    td1_nxt       = td1_r;
    walk_nxt      = walk_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;

    if (walk_r) begin
      // Walk the bitmap, emit each missing number
      if (miss[idx_r]) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_MISSING;
        out_num_nxt   = 16'(idx_r) + 16'd1;
        out_last_nxt  = (rest == map_t'(0));
      end
      if ((miss[idx_r] && (rest == map_t'(0))) || (idx_r == MAP_IW'(MAX_PACKETS - 1))) begin
        walk_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + MAP_IW'(1);
      end
    end else if (accept) begin
      case (in_req_type)
        REQ_PACKET: begin
          // Shift the tail delay, advance or close the packet
          if (in_packet_end) begin
            pos_nxt       = '0;
            num_nxt       = '0;
            td0_nxt       = '0;
            td1_nxt       = '0;
            out_valid_nxt = 1'b1;
            out_num_nxt   = end_num;
            out_last_nxt  = 1'b1;
            if (drop) begin
              out_kind_nxt = KIND_DROPPED;
            end else begin
              map_nxt = map_r | map_set;
              fpd_nxt = fpd_new;
              if (!fpd_new) begin
                out_kind_nxt = KIND_PENDING;
              end else begin
                all_nxt      = all_new;
                out_kind_nxt = all_new ? KIND_COMPLETE : KIND_SOME;
              end
            end
          end else begin
            num_nxt = num_new;
            td0_nxt = td1_r;
            td1_nxt = in_data_byte;
            if (pos_r < POS_MAX) begin
              pos_nxt = pos_r + 11'd1;
            end
          end
        end
        REQ_LIST: begin
          // Nothing missing gives one result, else start the walk
          if (miss == map_t'(0)) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_COMPLETE;
            out_num_nxt   = '0;
            out_last_nxt  = 1'b1;
          end else begin
            walk_nxt = 1'b1;
            idx_nxt  = '0;
          end
        end
        REQ_READ: begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_IMAGE;
          out_num_nxt   = '0;
          out_last_nxt  = 1'b1;
        end
        default: begin
          // New picture: clear bitmap, flags and packet state
          map_nxt = '0;
          fpd_nxt = 1'b0;
          all_nxt = 1'b0;
          pos_nxt = '0;
          num_nxt = '0;
          td0_nxt = '0;
          td1_nxt = '0;
        end
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_count_r <= 7'(MAX_PACKETS);
      image_bytes_r  <= 17'(IMAGE_DEPTH);
      map_r          <= '0;
      fpd_r          <= 1'b0;
      all_r          <= 1'b0;
      pos_r          <= '0;
      num_r          <= '0;
      td0_r          <= '0;
      td1_r          <= '0;
      walk_r         <= 1'b0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
      out_kind_r     <= KIND_PENDING;
      out_num_r      <= '0;
      out_last_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PACKET_COUNT: packet_count_r <= cfg_data[6:0];
          CFG_IMAGE_BYTES:  image_bytes_r  <= cfg_data;
          default:          ;
        endcase
      end
      map_r       <= map_nxt;
      fpd_r       <= fpd_nxt;
      all_r       <= all_nxt;
      pos_r       <= pos_nxt;
      num_r       <= num_nxt;
      td0_r       <= td0_nxt;
      td1_r       <= td1_nxt;
      walk_r      <= walk_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_kind_r  <= out_kind_nxt;
      out_num_r   <= out_num_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Image memory: one write port for payload, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      img_mem[wr_addr[IMG_AW-1:0]] <= td0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= img_mem[in_read_address[IMG_AW-1:0]];
    end
  end

  // Result ports
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_packet_number = out_num_r;
  assign out_image_data    = (out_kind_r == KIND_IMAGE) ? rd_q_r : 8'd0;
  assign out_last          = out_last_r;

  // Checks
  `include "image_packet_reassembly_macros.svh"

  `IPR_ASSERT_SAME(a_single_result_last, out_valid && (out_kind != KIND_MISSING), out_last)
  `IPR_ASSERT_SAME(a_walk_end_last, $fell(walk_r) && $past(rst_n), out_valid && out_last)
  `IPR_ASSERT_SAME(a_missing_in_range, out_valid && (out_kind == KIND_MISSING), (out_packet_number != 16'd0) && (out_packet_number <= cnt16))
  `IPR_ASSERT_NEXT(a_list_blocks, walk_r && !(miss[idx_r] && (rest == map_t'(0))) && (idx_r != MAP_IW'(MAX_PACKETS - 1)), busy)

endmodule
`default_nettype wire
